>>> rtl/lcc_pkg.sv
`timescale 1ns / 1ps
// lcc_pkg: shared types and constants for the LBA to CHS converter.
// Used by lcc_geom, lcc_div_stage and lba_to_chs_convert; no dependencies.
package lcc_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegGeomValid = 3'd0;
  localparam logic [2:0] RegBiosCyl   = 3'd1;
  localparam logic [2:0] RegBiosHeads = 3'd2;
  localparam logic [2:0] RegBiosSect  = 3'd3;
  localparam logic [2:0] RegTotalSect = 3'd4;
  localparam logic [2:0] RegHardDisk  = 3'd5;
  localparam logic [2:0] RegCylMode   = 3'd6;

  // Cylinder mode codes (the unused code behaves as strict)
  localparam logic [1:0] ModeStrict = 2'd0;
  localparam logic [1:0] ModeAddOne = 2'd1;
  localparam logic [1:0] ModeMax    = 2'd2;

  // Field widths
  localparam int CylW  = 11;
  localparam int HeadW = 9;
  localparam int SectW = 6;
  localparam int CfgW  = 64;
  // Largest geometry is 2047*511*63 < 2^26 sectors
  localparam int CapW  = 26;
  localparam int TrackW = 20;

  // Restoring divider: one quotient bit per step
  localparam int WorkW         = 28;
  localparam int RemW          = HeadW;
  localparam int StepsPerStage = 7;
  localparam int SectStages    = 4;   // 28 steps, divide by sectors
  localparam int HeadStages    = 3;   // 21 steps, divide by heads
  localparam int NumStages     = SectStages + HeadStages;

  // Fallback geometries
  localparam logic [CylW-1:0]  MaxCyl       = 11'd1024;
  localparam logic [CylW-1:0]  HdCyl        = 11'd1024;
  localparam logic [HeadW-1:0] HdHeads      = 9'd255;
  localparam logic [SectW-1:0] HdSect       = 6'd63;
  localparam logic [CapW-1:0]  HdCap        = CapW'(1024 * 255 * 63);
  localparam logic [CylW-1:0]  FdCyl        = 11'd80;
  localparam logic [HeadW-1:0] FdHeads      = 9'd2;
  localparam logic [SectW-1:0] FdSect       = 6'd18;
  localparam logic [CapW-1:0]  FdCap        = CapW'(80 * 2 * 18);

  // Item moving through the divider stages
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [WorkW-1:0] work;
    logic [CapW-1:0]  lba;     // low address bits, for the range check
    logic             hi;      // address bits above the largest geometry set
    logic [SectW-1:0] sect;    // remainder of the sector division
  } item_t;

  // Effective geometry
  typedef struct packed {
    logic [CylW-1:0]  cyls;
    logic [HeadW-1:0] heads;
    logic [SectW-1:0] sects;
    logic [CapW-1:0]  cap;
  } geom_t;

endpackage

>>> rtl/lcc_geom.sv
`timescale 1ns / 1ps
// lcc_geom: configuration registers and effective geometry derivation.
// Depends on lcc_pkg.
module lcc_geom (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [lcc_pkg::CfgW-1:0]    cfg_data,
  output logic [lcc_pkg::HeadW-1:0]   heads_early,
  output logic [lcc_pkg::SectW-1:0]   sects_early,
  output lcc_pkg::geom_t              geom
);

  logic                          geom_valid_r;
  logic [lcc_pkg::CylW-1:0]      bios_cyl_r;
  logic [lcc_pkg::HeadW-1:0]     bios_heads_r;
  logic [lcc_pkg::SectW-1:0]     bios_sect_r;
  logic [lcc_pkg::CfgW-1:0]      total_sect_r;
  logic                          hard_disk_r;
  logic [1:0]                    cyl_mode_r;

  logic [19:0]                   ch_r;
  logic [14:0]                   hs_r;
  logic [lcc_pkg::CapW-1:0]      chs_r;
  lcc_pkg::geom_t                geom_r;
  lcc_pkg::geom_t                geom_nxt;
  logic                          bump;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_valid_r <= 1'b0;
      bios_cyl_r   <= 11'd1024;
      bios_heads_r <= 9'd255;
      bios_sect_r  <= 6'd63;
      total_sect_r <= '0;
      hard_disk_r  <= 1'b1;
      cyl_mode_r   <= lcc_pkg::ModeAddOne;
    end else if (cfg_we) begin
      case (cfg_index)
        lcc_pkg::RegGeomValid: geom_valid_r <= cfg_data[0];
        lcc_pkg::RegBiosCyl:   bios_cyl_r   <= cfg_data[lcc_pkg::CylW-1:0];
        lcc_pkg::RegBiosHeads: bios_heads_r <= cfg_data[lcc_pkg::HeadW-1:0];
        lcc_pkg::RegBiosSect:  bios_sect_r  <= cfg_data[lcc_pkg::SectW-1:0];
        lcc_pkg::RegTotalSect: total_sect_r <= cfg_data;
        lcc_pkg::RegHardDisk:  hard_disk_r  <= cfg_data[0];
        lcc_pkg::RegCylMode:   cyl_mode_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Heads and sectors do not depend on the cylinder mode; divider uses them directly
  always_comb begin
    if (geom_valid_r) begin
      heads_early = bios_heads_r;
      sects_early = bios_sect_r;
    end else if (hard_disk_r) begin
      heads_early = lcc_pkg::HdHeads;
      sects_early = lcc_pkg::HdSect;
    end else begin
      heads_early = lcc_pkg::FdHeads;
      sects_early = lcc_pkg::FdSect;
    end
  end

  // Products, one multiply per register
  always_ff @(posedge clk) begin
    ch_r  <= 20'(bios_cyl_r) * 20'(bios_heads_r);
    hs_r  <= 15'(bios_heads_r) * 15'(bios_sect_r);
    chs_r <= lcc_pkg::CapW'(ch_r) * lcc_pkg::CapW'(bios_sect_r);
  end

  // Mode handling and capacity
  assign bump = (bios_cyl_r < 11'd1024) && (total_sect_r > {38'd0, chs_r});

  always_comb begin
    geom_nxt.heads = heads_early;
    geom_nxt.sects = sects_early;
    if (geom_valid_r) begin
      case (cyl_mode_r)
        lcc_pkg::ModeAddOne: begin
          geom_nxt.cyls = bios_cyl_r + {10'd0, bump};
          geom_nxt.cap  = chs_r + (bump ? {11'd0, hs_r} : '0);
        end
        lcc_pkg::ModeMax: begin
          geom_nxt.cyls = lcc_pkg::MaxCyl;
          geom_nxt.cap  = {1'b0, hs_r, 10'd0};
        end
        default: begin
          geom_nxt.cyls = bios_cyl_r;
          geom_nxt.cap  = chs_r;
        end
      endcase
    end else if (hard_disk_r) begin
      geom_nxt.cyls = lcc_pkg::HdCyl;
      geom_nxt.cap  = lcc_pkg::HdCap;
    end else begin
      geom_nxt.cyls = lcc_pkg::FdCyl;
      geom_nxt.cap  = lcc_pkg::FdCap;
    end
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

>>> rtl/lcc_div_stage.sv
`timescale 1ns / 1ps
// lcc_div_stage: one pipeline stage of the restoring divider, a fixed number
// of quotient bits per stage, with its own valid/ready register. Depends on lcc_pkg.
module lcc_div_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  lcc_pkg::item_t             up_item,
  input  logic [lcc_pkg::RemW-1:0]   divisor,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output lcc_pkg::item_t             dn_item
);

  logic           valid_r;
  lcc_pkg::item_t item_r;
  lcc_pkg::item_t item_nxt;

  // Stage is free when empty or when its content moves on
  assign up_ready = !valid_r || dn_ready;

  // Shift-subtract steps
  always_comb begin : div_steps
    logic [lcc_pkg::RemW:0] trial;
    item_nxt = up_item;
    for (int i = 0; i < lcc_pkg::StepsPerStage; i++) begin
      trial = {item_nxt.rem, item_nxt.work[lcc_pkg::WorkW-1]};
      item_nxt.work = {item_nxt.work[lcc_pkg::WorkW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
        item_nxt.work[0] = 1'b1;
      end
      item_nxt.rem = trial[lcc_pkg::RemW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

>>> rtl/lba_to_chs_convert.sv
`timescale 1ns / 1ps
// lba_to_chs_convert: top level, LBA to packed cylinder/head/sector bytes.
// Depends on lcc_pkg, lcc_geom and lcc_div_stage.
//
// Converts a 64-bit logical block address into the three CHS bytes used by
// BIOS disk services. One address is taken every clock cycle unless output
// backpressure holds the pipeline; each result passes through the divider
// stages and then the output register. Four divider stages divide by sectors
// per track and three by heads, seven quotient bits per stage; the output
// register also applies the end-of-disk clamp. Every stage has its own
// valid bit and takes a new item whenever it is empty, so bubbles close up
// under output backpressure. Register writes reach the geometry through the
// product registers and the geometry register.
module lba_to_chs_convert (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [lcc_pkg::CfgW-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [63:0]                 in_lba,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_head_byte,
  output logic [7:0]                  out_sector_byte,
  output logic [7:0]                  out_cylinder_byte
);

  logic [lcc_pkg::HeadW-1:0] heads_early;
  logic [lcc_pkg::SectW-1:0] sects_early;
  lcc_pkg::geom_t            geom;

  logic           st_valid [0:lcc_pkg::NumStages];
  logic           st_ready [0:lcc_pkg::NumStages];
  lcc_pkg::item_t st_item  [0:lcc_pkg::NumStages];

  logic                      out_valid_r;
  logic [7:0]                head_r;
  logic [7:0]                sector_r;
  logic [7:0]                cyl_r;
  logic [7:0]                head_nxt;
  logic [7:0]                sector_nxt;
  logic [7:0]                cyl_nxt;
  logic                      clamp;
  logic [lcc_pkg::HeadW-1:0] head_last;
  logic [lcc_pkg::CylW-1:0]  cyl_last;
  logic [lcc_pkg::SectW-1:0] sect_one;
  lcc_pkg::item_t            last_item;

  lcc_geom u_geom (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .heads_early (heads_early),
    .sects_early (sects_early),
    .geom        (geom)
  );

  // Entry: dividend is the address below the largest possible capacity
  always_comb begin
    st_item[0].rem  = '0;
    st_item[0].work = {2'd0, in_lba[lcc_pkg::CapW-1:0]};
    st_item[0].lba  = in_lba[lcc_pkg::CapW-1:0];
    st_item[0].hi   = |in_lba[63:lcc_pkg::CapW];
    st_item[0].sect = '0;
  end
  assign st_valid[0] = in_valid;
  assign in_ready    = st_ready[0];

  // Divider chain: sectors first, then track by heads
  for (genvar k = 0; k < lcc_pkg::NumStages; k++) begin : g_stage
    lcc_pkg::item_t            stage_in;
    logic [lcc_pkg::RemW-1:0]  stage_div;

    if (k == lcc_pkg::SectStages) begin : g_reload
      // Sector remainder is kept, the track restarts as a new dividend
      always_comb begin
        stage_in      = st_item[k];
        stage_in.rem  = '0;
        stage_in.work = {1'b0, st_item[k].work[lcc_pkg::TrackW-1:0],
                         (lcc_pkg::WorkW - lcc_pkg::TrackW - 1)'(0)};
        stage_in.sect = st_item[k].rem[lcc_pkg::SectW-1:0];
      end
    end else begin : g_pass
      assign stage_in = st_item[k];
    end

    if (k < lcc_pkg::SectStages) begin : g_by_sect
      assign stage_div = {3'd0, sects_early};
    end else begin : g_by_head
      assign stage_div = heads_early;
    end

    lcc_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[k]),
      .up_ready (st_ready[k]),
      .up_item  (stage_in),
      .divisor  (stage_div),
      .dn_valid (st_valid[k+1]),
      .dn_ready (st_ready[k+1]),
      .dn_item  (st_item[k+1])
    );
  end

  // Output stage: clamp and byte packing
  assign last_item = st_item[lcc_pkg::NumStages];
  assign clamp     = last_item.hi || (last_item.lba >= geom.cap);
  assign head_last = geom.heads - 9'd1;
  assign cyl_last  = geom.cyls - 11'd1;
  assign sect_one  = last_item.sect + 6'd1;

  always_comb begin
    if (clamp) begin
      head_nxt   = head_last[7:0];
      sector_nxt = {cyl_last[9:8], geom.sects};
      cyl_nxt    = cyl_last[7:0];
    end else begin
      head_nxt   = last_item.rem[7:0];
      sector_nxt = {last_item.work[9:8], sect_one};
      cyl_nxt    = last_item.work[7:0];
    end
  end

  assign st_ready[lcc_pkg::NumStages] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_ready[lcc_pkg::NumStages]) begin
      out_valid_r <= st_valid[lcc_pkg::NumStages];
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready[lcc_pkg::NumStages] && st_valid[lcc_pkg::NumStages]) begin
      head_r   <= head_nxt;
      sector_r <= sector_nxt;
      cyl_r    <= cyl_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_head_byte     = head_r;
  assign out_sector_byte   = sector_r;
  assign out_cylinder_byte = cyl_r;

endmodule

>>> verif/lba_chs_checker.sv
`timescale 1ns / 1ps
// lba_chs_checker: watches the config, address and CHS channels of
// lba_to_chs_convert, predicts each CHS triplet and compares. Depends on lcc_pkg.
module lba_chs_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [lcc_pkg::CfgW-1:0] cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [63:0]              in_lba,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [7:0]               out_head_byte,
  input  logic [7:0]               out_sector_byte,
  input  logic [7:0]               out_cylinder_byte,
  output int                       fail_count,
  output int                       pending
);
  import lcc_pkg::*;

  typedef struct packed {
    logic [63:0] lba;
    logic [7:0]  head_byte;
    logic [7:0]  sector_byte;
    logic [7:0]  cylinder_byte;
  } chs_t;

  // Shadow copy of the geometry registers
  logic             geom_valid;
  logic [CylW-1:0]  bios_cyl;
  logic [HeadW-1:0] bios_heads;
  logic [SectW-1:0] bios_sect;
  logic [63:0]      total_sect;
  logic             hard_disk;
  logic [1:0]       cyl_mode;

  chs_t chs_expected[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  // Effective geometry, end-of-disk clamp, then pack into the three bytes
  function automatic chs_t predict_chs(input logic [63:0] lba);
    logic [63:0] cs, hs, ss, cap, track;
    logic [31:0] c, h, s;
    chs_t r;
    if (geom_valid) begin
      cs = 64'(bios_cyl);
      hs = 64'(bios_heads);
      ss = 64'(bios_sect);
      if (cyl_mode == ModeAddOne) begin
        if (cs < 64'(MaxCyl) && total_sect > cs * hs * ss) cs = cs + 1;
      end else if (cyl_mode == ModeMax) begin
        cs = 64'(MaxCyl);
      end
    end else if (hard_disk) begin
      cs = 64'(HdCyl);
      hs = 64'(HdHeads);
      ss = 64'(HdSect);
    end else begin
      cs = 64'(FdCyl);
      hs = 64'(FdHeads);
      ss = 64'(FdSect);
    end
    cap = cs * hs * ss;
    if (lba >= cap) begin
      // past the end (or an empty geometry): last sector, counts minus one
      s = ss[31:0];
      h = hs[31:0] - 32'd1;
      c = cs[31:0] - 32'd1;
    end else begin
      track = lba / ss;
      s = 32'(lba % ss) + 32'd1;
      h = 32'(track % hs);
      c = 32'(track / hs);
    end
    r.lba           = lba;
    r.head_byte     = h[7:0];
    r.sector_byte   = s[7:0] | {c[9:8], 6'b0};
    r.cylinder_byte = c[7:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    chs_t want;
    if (!rst_n) begin
      geom_valid <= 1'b0;
      bios_cyl   <= HdCyl;
      bios_heads <= HdHeads;
      bios_sect  <= HdSect;
      total_sect <= 64'd0;
      hard_disk  <= 1'b1;
      cyl_mode   <= ModeAddOne;
      chs_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegGeomValid: geom_valid <= cfg_data[0];
          RegBiosCyl:   bios_cyl   <= cfg_data[CylW-1:0];
          RegBiosHeads: bios_heads <= cfg_data[HeadW-1:0];
          RegBiosSect:  bios_sect  <= cfg_data[SectW-1:0];
          RegTotalSect: total_sect <= cfg_data;
          RegHardDisk:  hard_disk  <= cfg_data[0];
          RegCylMode:   cyl_mode   <= cfg_data[1:0];
          default: ;
        endcase
      end
      // address transfer: queue its triplet
      if (in_valid && in_ready) chs_expected.push_back(predict_chs(in_lba));
      // result transfer: compare with the oldest triplet
      if (out_valid && out_ready) begin
        if (chs_expected.size() == 0) begin
          report($sformatf("unexpected result h=%h s=%h c=%h",
                           out_head_byte, out_sector_byte, out_cylinder_byte));
        end else begin
          want = chs_expected.pop_front();
          if (out_head_byte !== want.head_byte)
            report($sformatf("lba %h head_byte got %h want %h",
                             want.lba, out_head_byte, want.head_byte));
          if (out_sector_byte !== want.sector_byte)
            report($sformatf("lba %h sector_byte got %h want %h",
                             want.lba, out_sector_byte, want.sector_byte));
          if (out_cylinder_byte !== want.cylinder_byte)
            report($sformatf("lba %h cylinder_byte got %h want %h",
                             want.lba, out_cylinder_byte, want.cylinder_byte));
        end
      end
    end
    pending <= chs_expected.size();
  end

endmodule

>>> verif/tb_lba_to_chs_convert.sv
`timescale 1ns / 1ps
// tb_lba_to_chs_convert: stimulus and verdict for lba_to_chs_convert.
// Depends on lcc_pkg, the RTL and lba_chs_checker.
module tb_lba_to_chs_convert;
  import lcc_pkg::*;

  localparam logic [2:0] RegUnused  = 3'd7;
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 12;
  localparam int SettleCycles = 4;
  localparam int StallCycles = 90;
  localparam int RandPhases = 16;
  localparam int ItemsPerPhase = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_lba = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_head_byte;
  logic [7:0]  out_sector_byte;
  logic [7:0]  out_cylinder_byte;
  logic        stall_req = 1'b0;

  int fail_count;
  int pending;
  int tx_idle_pct = 38;
  int rx_idle_pct = 88;
  int stall_left = 0;
  int cycle_count = 0;

  always #4 clk = ~clk;

  lba_to_chs_convert DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_lba            (in_lba),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_head_byte     (out_head_byte),
    .out_sector_byte   (out_sector_byte),
    .out_cylinder_byte (out_cylinder_byte)
  );

  lba_chs_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_lba            (in_lba),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_head_byte     (out_head_byte),
    .out_sector_byte   (out_sector_byte),
    .out_cylinder_byte (out_cylinder_byte),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Receiver: random ready, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req) begin
      out_ready  <= 1'b0;
      stall_left <= StallCycles;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_lba_to_chs_convert: errors");
      $finish;
    end
  end

  // One address transfer, with optional idle cycles first
  task automatic send_lba(input logic [63:0] lba);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lba   <= lba;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait until every triplet is back and the pipeline has emptied
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write the whole register set while idle; index 7 gets junk
  task automatic load_geometry(input logic [63:0] valid, cyls, heads, sects, total,
                               hd, mode);
    drain();
    write_reg(RegUnused, {$urandom, $urandom});
    write_reg(RegGeomValid, valid);
    write_reg(RegBiosCyl, cyls);
    write_reg(RegBiosHeads, heads);
    write_reg(RegBiosSect, sects);
    write_reg(RegTotalSect, total);
    write_reg(RegHardDisk, hd);
    write_reg(RegCylMode, mode);
    cfg_we <= 1'b0;
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Random bits above a register's width; the block must drop them
  function automatic logic [63:0] with_junk(input logic [63:0] v, input int w);
    if ($urandom_range(0, 1) == 1) return v | ({$urandom, $urandom} << w);
    return v;
  endfunction

  // Mostly inside the disk, some at its end, some anywhere in 64 bits
  function automatic logic [63:0] pick_lba(input logic [63:0] cap_hint);
    int r;
    r = $urandom_range(0, 9);
    if (cap_hint == 0 || r >= 8) return {$urandom, $urandom};
    if (r >= 6) return cap_hint - 64'd2 + 64'($urandom_range(0, 4));
    return {$urandom, $urandom} % cap_hint;
  endfunction

  initial begin : stimulus
    logic [63:0] valid, cyls, heads, sects, total, hd, mode, cap_guess, cap_hint;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset geometry, hard disk fallback
    send_lba(64'd0);
    send_lba(64'd1);
    send_lba(64'd62);
    send_lba(64'd63);
    send_lba(64'(HdCap) - 64'd1);
    send_lba(64'(HdCap));
    send_lba('1);
    send_lba(64'h8000_0000_0000_0000);
    // floppy fallback
    load_geometry(0, 1024, 255, 63, 0, 0, 64'(ModeAddOne));
    send_lba(64'd0);
    send_lba(64'd36);
    send_lba(64'(FdCap) - 64'd1);
    send_lba(64'(FdCap));
    // largest geometry, strict: cylinder bits above 9 dropped
    load_geometry(1, 2047, 511, 63, 0, 1, 64'(ModeStrict));
    send_lba(64'd2047 * 511 * 63 - 1);
    send_lba(64'd2047 * 511 * 63);
    // zero heads, zero sectors, zero cylinders: empty geometry clamps
    load_geometry(1, 10, 0, 63, 0, 1, 64'(ModeStrict));
    send_lba(64'd0);
    load_geometry(1, 10, 4, 0, 0, 1, 64'(ModeStrict));
    send_lba(64'd7);
    load_geometry(1, 0, 4, 8, 0, 1, 64'(ModeStrict));
    send_lba(64'd3);
    // unused mode acts strict even with a huge disk
    load_geometry(1, 10, 4, 8, '1, 1, 64'(ModeUnused));
    send_lba(64'd320);
    // max mode forces 1024 cylinders
    load_geometry(1, 10, 4, 8, 0, 1, 64'(ModeMax));
    send_lba(64'd32767);
    send_lba(64'd32768);
    // add mode bumps one cylinder when the disk is larger
    load_geometry(1, 10, 4, 8, 321, 1, 64'(ModeAddOne));
    send_lba(64'd320);
    send_lba(64'd352);
    // add mode does not bump at 1024 cylinders
    load_geometry(1, 1024, 2, 2, '1, 1, 64'(ModeAddOne));
    send_lba(64'd4096);

    // Random geometries and addresses
    for (int ph = 0; ph < RandPhases; ph++) begin
      valid = 64'($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0: cyls = 1;
        1: cyls = 1024;
        2: cyls = 2047;
        3: cyls = 64'($urandom_range(0, 2047));
        default: cyls = 64'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 5))
        0: heads = 1;
        1: heads = 255;
        2: heads = 256;
        3: heads = 511;
        4: heads = 64'($urandom_range(0, 16));
        default: heads = 64'($urandom_range(1, 511));
      endcase
      case ($urandom_range(0, 2))
        0: sects = 1;
        1: sects = 63;
        default: sects = 64'($urandom_range(0, 63));
      endcase
      cap_guess = cyls * heads * sects;
      case ($urandom_range(0, 4))
        0: total = 0;
        1: total = '1;
        2: total = {$urandom, $urandom};
        default: total = cap_guess + 64'($urandom_range(0, 2)) - 64'd1;
      endcase
      hd   = 64'($urandom_range(0, 1));
      mode = 64'($urandom_range(0, 3));
      if (!valid)
        cap_hint = hd[0] ? 64'(HdCap) : 64'(FdCap);
      else if (mode == 64'(ModeMax))
        cap_hint = 64'(MaxCyl) * heads * sects;
      else
        cap_hint = (cyls + 1) * heads * sects;

      // idling profile by phase
      if (ph < 6) begin
        tx_idle_pct = 38;
        rx_idle_pct = 88;
      end else if (ph < 11) begin
        tx_idle_pct = 88;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      load_geometry(with_junk(valid, 1), with_junk(cyls, CylW), with_junk(heads, HeadW),
                    with_junk(sects, SectW), total, with_junk(hd, 1), with_junk(mode, 2));

      // long receiver hold-off while addresses keep coming
      if (ph == 11) begin
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
      end
      for (int i = 0; i < ItemsPerPhase; i++) send_lba(pick_lba(cap_hint));
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_lba_to_chs_convert: clean");
    end else begin
      $display("tb_lba_to_chs_convert: errors");
    end
    $finish;
  end

endmodule
